// ===== sv/first_fit_heap_allocator_macros.svh =====
// Assertion macros shared by the first-fit heap allocator modules.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, muted while reset is asserted.
`define FFHA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");

// Checked property that also holds during reset.
`define FFHA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`else

`define FFHA_ASSERT(label, clk, rstn, prop)
`define FFHA_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== sv/ffha_pkg.sv =====
// Package with constants, command codes and control types of the heap allocator.
package ffha_pkg;

    localparam int HEAP_BYTES = 65536;
    localparam int ADDR_W     = $clog2(HEAP_BYTES);
    localparam int POS_W      = ADDR_W + 1;
    localparam int SIZE_W     = 16;
    localparam int CMP_W      = 18;

    localparam logic [CMP_W-1:0]  HEAP_END  = CMP_W'(HEAP_BYTES);
    localparam logic [CMP_W-1:0]  HDR_LEN   = CMP_W'(3);
    localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(HEAP_BYTES - 3);

    localparam logic [7:0] FLAG_FREE = 8'h31;
    localparam logic [7:0] FLAG_USED = 8'h32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_START,
        OP_RD0,
        OP_RD1,
        OP_RD2,
        OP_LATCH,
        OP_EVAL,
        OP_ADV,
        OP_WFLAG,
        OP_W1,
        OP_W2,
        OP_W3,
        OP_W4,
        OP_W5,
        OP_WFREE,
        OP_OUT_ALLOC,
        OP_OUT_FREE,
        OP_OUT_FAIL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic pos_end;
        logic fail;
        logic fit;
        logic split;
        logic free_ok;
    } dp_status_t;

endpackage

// ===== sv/ffha_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ffha_datapath.sv =====
// Datapath of the heap allocator: heap store, header registers, compares and result register.
`include "first_fit_heap_allocator_macros.svh"

module ffha_datapath import ffha_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    input  logic [SIZE_W-1:0] s_request_size,
    input  logic [15:0]       s_block_address,
    output dp_status_t        sts,
    output logic              m_ok,
    output logic [15:0]       m_payload_address
);

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SIZE_W-1:0] want_reg;
    logic [15:0]       baddr_reg;
    logic [7:0]        flag_reg;
    logic [7:0]        hi_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] split_pos_reg, split_pos_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic              ok_reg;
    logic [15:0]       paddr_reg;

    logic [CMP_W-1:0]  pos_w, size_w, want_w, baddr_w;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic [7:0]        clear_byte;

    assign pos_w   = CMP_W'(pos_reg);
    assign size_w  = CMP_W'(size_reg);
    assign want_w  = CMP_W'(want_reg);
    assign baddr_w = CMP_W'(baddr_reg);

    assign clr_cnt_next   = clr_cnt_reg + ADDR_W'(1);
    assign pos_next       = POS_W'(pos_w + size_w + HDR_LEN);
    assign split_pos_next = ADDR_W'(pos_w + want_w + HDR_LEN);
    assign rem_next       = SIZE_W'(size_w - want_w - HDR_LEN);

    // Status toward the controller. A truncated header also makes the
    // overrun term meaningless, but the walk fails either way.
    always_comb begin
        sts.clear_last = (clr_cnt_reg == ADDR_W'(HEAP_BYTES - 1));
        sts.pos_end    = (pos_w >= HEAP_END);
        sts.fail       = (pos_w > HEAP_END - HDR_LEN) ||
                         (size_w > HEAP_END - HDR_LEN - pos_w);
        sts.fit        = (flag_reg != FLAG_USED) && (size_w >= want_w);
        sts.split      = (size_w > want_w + HDR_LEN);
        sts.free_ok    = (baddr_w >= HDR_LEN) && (baddr_w - HDR_LEN < HEAP_END);
    end

    // Reset image: a free header at offset zero covering the heap, zeros elsewhere.
    always_comb begin
        if (clr_cnt_reg == ADDR_W'(0)) begin
            clear_byte = FLAG_FREE;
        end else if (clr_cnt_reg == ADDR_W'(1)) begin
            clear_byte = INIT_SIZE[15:8];
        end else if (clr_cnt_reg == ADDR_W'(2)) begin
            clear_byte = INIT_SIZE[7:0];
        end else begin
            clear_byte = 8'h00;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(pos_reg);
        ram_wdata = FLAG_USED;
        ram_raddr = ADDR_W'(pos_reg);
        unique case (cmd.op)
            OP_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = clear_byte;
            end
            OP_RD1: ram_raddr = ADDR_W'(pos_reg + POS_W'(1));
            OP_RD2: ram_raddr = ADDR_W'(pos_reg + POS_W'(2));
            OP_WFLAG: begin
                ram_we    = 1'b1;
                ram_wdata = FLAG_USED;
            end
            OP_W1: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(pos_reg + POS_W'(1));
                ram_wdata = want_reg[15:8];
            end
            OP_W2: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(pos_reg + POS_W'(2));
                ram_wdata = want_reg[7:0];
            end
            OP_W3: begin
                ram_we    = 1'b1;
                ram_waddr = split_pos_reg;
                ram_wdata = FLAG_FREE;
            end
            OP_W4: begin
                ram_we    = 1'b1;
                ram_waddr = split_pos_reg + ADDR_W'(1);
                ram_wdata = rem_reg[15:8];
            end
            OP_W5: begin
                ram_we    = 1'b1;
                ram_waddr = split_pos_reg + ADDR_W'(2);
                ram_wdata = rem_reg[7:0];
            end
            OP_WFREE: begin
                ram_we    = sts.free_ok;
                ram_waddr = ADDR_W'(baddr_w - HDR_LEN);
                ram_wdata = FLAG_FREE;
            end
            default: begin
            end
        endcase
    end

    ffha_ram #(
        .WIDTH(8),
        .DEPTH(HEAP_BYTES)
    ) u_heap (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.op == OP_CLEAR) begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_START: begin
                pos_reg   <= '0;
                want_reg  <= s_request_size;
                baddr_reg <= s_block_address;
            end
            OP_RD1:   flag_reg <= ram_rdata;
            OP_RD2:   hi_reg   <= ram_rdata;
            OP_LATCH: size_reg <= {hi_reg, ram_rdata};
            OP_EVAL: begin
                split_pos_reg <= split_pos_next;
                rem_reg       <= rem_next;
            end
            OP_ADV:   pos_reg <= pos_next;
            OP_OUT_ALLOC: begin
                ok_reg    <= 1'b1;
                paddr_reg <= 16'(pos_w + HDR_LEN);
            end
            OP_OUT_FREE: begin
                ok_reg    <= sts.free_ok;
                paddr_reg <= 16'h0000;
            end
            OP_OUT_FAIL: begin
                ok_reg    <= 1'b0;
                paddr_reg <= 16'h0000;
            end
            default: begin
            end
        endcase
    end

    assign m_ok              = ok_reg;
    assign m_payload_address = paddr_reg;

    `FFHA_ASSERT(a_walk_moves_forward, aclk, aresetn, (cmd.op == OP_ADV) |=> (pos_reg > $past(pos_reg)))
    `FFHA_ASSERT(a_split_after_header, aclk, aresetn, (cmd.op == OP_W3) |-> (CMP_W'(split_pos_reg) >= pos_w + HDR_LEN))

endmodule

// ===== sv/ffha_ctrl.sv =====
// Controller state machine of the heap allocator: clearing pass, header walk and result handoff.
`include "first_fit_heap_allocator_macros.svh"

module ffha_ctrl import ffha_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_command,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_LATCH,
        ST_EVAL,
        ST_W0,
        ST_W1,
        ST_W2,
        ST_W3,
        ST_W4,
        ST_W5,
        ST_WFLAG,
        ST_DONE_ALLOC,
        ST_DONE_FREE,
        ST_DONE_FAIL
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = OP_NOP;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_START;
                    state_next = (s_command == CMD_FREE) ? ST_FREE : ST_RD0;
                end
            end
            ST_FREE: begin
                cmd.op     = OP_WFREE;
                state_next = ST_DONE_FREE;
            end
            ST_RD0: begin
                if (sts.pos_end) begin
                    state_next = ST_DONE_FAIL;
                end else begin
                    cmd.op     = OP_RD0;
                    state_next = ST_RD1;
                end
            end
            ST_RD1: begin
                cmd.op     = OP_RD1;
                state_next = ST_RD2;
            end
            ST_RD2: begin
                cmd.op     = OP_RD2;
                state_next = ST_LATCH;
            end
            ST_LATCH: begin
                cmd.op     = OP_LATCH;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                priority if (sts.fail) begin
                    state_next = ST_DONE_FAIL;
                end else if (sts.fit && sts.split) begin
                    cmd.op     = OP_EVAL;
                    state_next = ST_W0;
                end else if (sts.fit) begin
                    state_next = ST_WFLAG;
                end else begin
                    cmd.op     = OP_ADV;
                    state_next = ST_RD0;
                end
            end
            ST_W0: begin
                cmd.op     = OP_WFLAG;
                state_next = ST_W1;
            end
            ST_W1: begin
                cmd.op     = OP_W1;
                state_next = ST_W2;
            end
            ST_W2: begin
                cmd.op     = OP_W2;
                state_next = ST_W3;
            end
            ST_W3: begin
                cmd.op     = OP_W3;
                state_next = ST_W4;
            end
            ST_W4: begin
                cmd.op     = OP_W4;
                state_next = ST_W5;
            end
            ST_W5: begin
                cmd.op     = OP_W5;
                state_next = ST_DONE_ALLOC;
            end
            ST_WFLAG: begin
                cmd.op     = OP_WFLAG;
                state_next = ST_DONE_ALLOC;
            end
            ST_DONE_ALLOC: begin
                if (out_free) begin
                    cmd.op       = OP_OUT_ALLOC;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DONE_FREE: begin
                if (out_free) begin
                    cmd.op       = OP_OUT_FREE;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DONE_FAIL: begin
                if (out_free) begin
                    cmd.op       = OP_OUT_FAIL;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `FFHA_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> (!s_ready && !m_valid))
    `FFHA_ASSERT(a_one_at_a_time, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    `FFHA_ASSERT(a_load_into_free_slot, aclk, aresetn, (cmd.op == OP_OUT_ALLOC || cmd.op == OP_OUT_FREE || cmd.op == OP_OUT_FAIL) |-> out_free)
    `FFHA_ASSERT(a_eval_inside_heap, aclk, aresetn, (state_reg == ST_EVAL) |-> !sts.pos_end)

endmodule

// ===== sv/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: controller and datapath joined by command and status.
//
// This block manages a byte heap as an implicit list of blocks, each a
// three-byte header (flag byte, then a big-endian 16-bit payload size)
// followed by its payload. An allocate request walks the headers from offset
// zero, takes the first block that is not marked used and is large enough,
// marks it used, and splits off a free remainder when more than three bytes
// would be left over; the result carries the payload offset (header offset
// plus three), or ok low and offset zero when no block fits or the chain runs
// past the heap end. A free request simply writes the free flag three bytes
// before the given offset, with no coalescing and no checking, and returns
// ok high unless that spot lies outside the heap. After reset the block runs
// a clearing pass over all HEAP_BYTES bytes (65536 by default) that writes
// the initial heap image one byte per cycle; s_ready stays low until it ends.
// The heap lives in a single RAM with one write and one registered read per
// cycle, so a header costs three reads: each visited header is read, its
// size latched and then evaluated. A fitting block is marked by writing its
// flag, or, when it splits, its flag, its new size and the three bytes of
// the remainder header. A failed allocation stops at a truncated or overlong
// header or when the walk runs to the heap end. One request is worked on at
// a time; the result waits in an output register, so a new request is
// accepted while a finished result is still waiting to be taken.

module first_fit_heap_allocator import ffha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_request_size,
    input  logic [15:0] s_block_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [15:0] m_payload_address
);

    // Command from the controller and status back from the datapath.
    dp_cmd_t    cmd;
    dp_status_t sts;

    // The controller sequences the clearing pass, the header walk and the
    // writes, and owns the handshake on both channels.
    ffha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_command(s_command),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the heap RAM, the current header and the result.
    ffha_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_request_size   (s_request_size),
        .s_block_address  (s_block_address),
        .sts              (sts),
        .m_ok             (m_ok),
        .m_payload_address(m_payload_address)
    );

endmodule

// ===== tb/heap_result_checker.sv =====
// Checker that mirrors the allocator heap and compares every result with its prediction.
`timescale 1ns / 100ps

module heap_result_checker import ffha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_request_size,
    input  logic [15:0] s_block_address,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_ok,
    input  logic [15:0] m_payload_address,
    output int          error_count,
    output int          pending_count
);

    localparam int HEADER_BYTES = 3;

    typedef struct packed {
        logic        ok;
        logic [15:0] payload_address;
    } grant_t;

    logic [7:0] heap_mirror [HEAP_BYTES];
    grant_t     expected_grants [$];
    grant_t     oldest;
    grant_t     predicted;
    int         failures = 0;

    function automatic void put_header(int at, logic [7:0] flag, int payload_bytes);
        heap_mirror[at]     = flag;
        heap_mirror[at + 1] = 8'(payload_bytes >> 8);
        heap_mirror[at + 2] = 8'(payload_bytes);
    endfunction

    function automatic void clear_heap_mirror();
        foreach (heap_mirror[i]) heap_mirror[i] = 8'h00;
        put_header(0, FLAG_FREE, HEAP_BYTES - HEADER_BYTES);
    endfunction

    // Applies one request to the mirror and returns the result it must produce.
    function automatic grant_t apply_heap_request(logic cmd, logic [15:0] req_size,
                                                  logic [15:0] blk_addr);
        grant_t g;
        int     pos;
        int     blk_size;
        int     want;
        bit     walking;
        g = '0;
        want = int'(req_size);
        if (cmd == CMD_ALLOC) begin
            pos = 0;
            walking = 1'b1;
            while (walking && pos < HEAP_BYTES) begin
                if (HEAP_BYTES - pos < HEADER_BYTES) begin
                    walking = 1'b0;
                end else begin
                    blk_size = int'({heap_mirror[pos + 1], heap_mirror[pos + 2]});
                    if (HEAP_BYTES - pos - HEADER_BYTES < blk_size) begin
                        // The chain runs past the end of the heap.
                        walking = 1'b0;
                    end else if (heap_mirror[pos] != FLAG_USED && blk_size >= want) begin
                        if (blk_size > want + HEADER_BYTES) begin
                            put_header(pos, FLAG_USED, want);
                            put_header(pos + HEADER_BYTES + want, FLAG_FREE,
                                       blk_size - want - HEADER_BYTES);
                        end else begin
                            heap_mirror[pos] = FLAG_USED;
                        end
                        g.ok = 1'b1;
                        g.payload_address = 16'(pos + HEADER_BYTES);
                        walking = 1'b0;
                    end else begin
                        pos += blk_size + HEADER_BYTES;
                    end
                end
            end
        end else if (int'(blk_addr) >= HEADER_BYTES &&
                     int'(blk_addr) - HEADER_BYTES < HEAP_BYTES) begin
            heap_mirror[int'(blk_addr) - HEADER_BYTES] = FLAG_FREE;
            g.ok = 1'b1;
        end
        return g;
    endfunction

    function automatic void report_field(string field, int want, int got);
        failures++;
        $display("%0t checker: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_heap_mirror();
            expected_grants.delete();
        end else begin
            // A result can never belong to a request accepted at the same edge,
            // so results are matched before the new request is queued.
            if (m_valid && m_ready) begin
                if (expected_grants.size() == 0) begin
                    failures++;
                    $display("%0t checker: result expected none, got ok %0d address %0d",
                             $time, m_ok, m_payload_address);
                end else begin
                    oldest = expected_grants.pop_front();
                    if (m_ok !== oldest.ok) begin
                        report_field("ok", oldest.ok, m_ok);
                    end
                    if (m_payload_address !== oldest.payload_address) begin
                        report_field("payload_address", oldest.payload_address,
                                     m_payload_address);
                    end
                end
            end
            if (s_valid && s_ready) begin
                predicted = apply_heap_request(s_command, s_request_size, s_block_address);
                expected_grants.push_back(predicted);
            end
        end
        pending_count <= expected_grants.size();
        error_count   <= failures;
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the heap allocator testbench: clock, reset, request stimulus, result sink and verdict.
`timescale 1ns / 100ps

module tb_top import ffha_pkg::*;;

    // Reset is held at the start; after it the block clears its whole heap, so
    // the watchdog limit must cover that quiet stretch several times over as
    // well as the longest header walk.
    localparam int RESET_CYCLES    = 8;
    localparam int QUIET_LIMIT     = 250000;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int PHASES          = 5;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = CMD_ALLOC;
    logic [15:0] s_request_size = '0;
    logic [15:0] s_block_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_ok;
    logic [15:0] m_payload_address;

    int error_count;
    int pending_count;

    // Knobs shared by the request and result sides.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_off_start     = 1'b0;
    int hold_off_left      = 0;
    int quiet_cycles       = 0;

    // Payload offsets handed out by successful allocations, used to build
    // frees that hit real block headers.
    logic [15:0] live_blocks [$];

    logic        rnd_cmd;
    logic [15:0] rnd_size;
    logic [15:0] rnd_addr;
    int          phase;

    always #5 aclk = ~aclk;

    first_fit_heap_allocator dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_request_size    (s_request_size),
        .s_block_address   (s_block_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_payload_address (m_payload_address)
    );

    heap_result_checker checker_inst (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_request_size    (s_request_size),
        .s_block_address   (s_block_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_payload_address (m_payload_address),
        .error_count       (error_count),
        .pending_count     (pending_count)
    );

    // Offers one request and returns at the edge where it is accepted. The
    // valid line drops only while the sender idles before the request, so
    // back-to-back requests keep it high without a glitch.
    task automatic send_request(input logic cmd, input logic [15:0] req_size,
                                input logic [15:0] blk_addr);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_request_size  <= req_size;
        s_block_address <= blk_addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Random request mix. Most traffic is well-formed: allocations of mostly
    // small sizes, now and then a very large one, and frees of blocks that
    // were handed out. The rest is noise that cannot damage the live part of
    // the block chain: frees below the first header slot, frees into the dead
    // tail region set up by the directed part, and repeated frees.
    task automatic pick_random_request(output logic cmd, output logic [15:0] req_size,
                                       output logic [15:0] blk_addr);
        int roll;
        int pick;
        int idx;
        roll     = $urandom_range(99);
        cmd      = CMD_ALLOC;
        req_size = 16'($urandom());
        blk_addr = 16'($urandom());
        if (roll < 55 || (roll < 90 && live_blocks.size() == 0)) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                req_size = 16'($urandom_range(24));
            end else if (pick < 95) begin
                req_size = 16'($urandom_range(300));
            end else if (pick < 99) begin
                req_size = 16'($urandom_range(4000));
            end else begin
                req_size = 16'($urandom_range(65535, 60000));
            end
        end else if (roll < 90) begin
            idx      = $urandom_range(live_blocks.size() - 1);
            cmd      = CMD_FREE;
            blk_addr = live_blocks[idx];
            live_blocks.delete(idx);
        end else begin
            pick = $urandom_range(2);
            cmd  = CMD_FREE;
            if (pick == 0) begin
                blk_addr = 16'($urandom_range(2));
            end else if (pick == 1 || live_blocks.size() == 0) begin
                // Everything from the dead tail header onward is never walked.
                blk_addr = 16'($urandom_range(65535, 61389));
            end else begin
                blk_addr = live_blocks[$urandom_range(live_blocks.size() - 1)];
            end
        end
    endtask

    // Result side: records handed-out offsets, stalls at random, and on
    // request holds off for a long stretch so the block fills and stalls
    // its request input.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready && m_ok && m_payload_address != '0) begin
                live_blocks.push_back(m_payload_address);
            end
            if (hold_off_start) begin
                hold_off_start = 1'b0;
                hold_off_left  = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Watchdog: too long without any accepted request or result ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[first_fit_heap_allocator] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part on the fresh heap, a single free block of 65533 bytes.
        // Requests above the heap and the exact fit, then a walk off the end.
        send_request(CMD_ALLOC, 16'hFFFF, 16'($urandom()));
        send_request(CMD_ALLOC, 16'd65534, 16'($urandom()));
        send_request(CMD_ALLOC, 16'd65533, 16'($urandom()));
        send_request(CMD_ALLOC, 16'd0, 16'($urandom()));
        send_request(CMD_FREE, 16'($urandom()), 16'd3);
        // Leftover of exactly three bytes keeps the old size; four bytes split.
        send_request(CMD_ALLOC, 16'd65530, 16'($urandom()));
        send_request(CMD_FREE, 16'($urandom()), 16'd3);
        send_request(CMD_ALLOC, 16'd65529, 16'($urandom()));
        // The one-byte remainder sits at the very top: its payload is 0xFFFF.
        send_request(CMD_ALLOC, 16'd1, 16'($urandom()));
        send_request(CMD_FREE, 16'($urandom()), 16'hFFFF);
        send_request(CMD_FREE, 16'($urandom()), 16'd3);
        // Split off a tail block at 61386 whose size low byte is 0x2F, so that
        // corrupting that byte with the free flag moves the next header to
        // 65534, where fewer than three bytes remain.
        send_request(CMD_ALLOC, 16'd61383, 16'($urandom()));
        send_request(CMD_ALLOC, 16'd4143, 16'($urandom()));
        send_request(CMD_FREE, 16'($urandom()), 16'd61389);
        send_request(CMD_FREE, 16'($urandom()), 16'd61391);
        send_request(CMD_ALLOC, 16'd4146, 16'($urandom()));
        // Now the size high byte: the tail block reaches past the heap end and
        // stays dead for the rest of the run, fencing off the random traffic.
        send_request(CMD_FREE, 16'($urandom()), 16'd61390);
        send_request(CMD_ALLOC, 16'd0, 16'($urandom()));
        // Frees below the first header slot are refused.
        send_request(CMD_FREE, 16'($urandom()), 16'd0);
        send_request(CMD_FREE, 16'($urandom()), 16'd2);
        // Front region is one free block of 61383 bytes again.
        send_request(CMD_FREE, 16'($urandom()), 16'd3);
        send_request(CMD_ALLOC, 16'd61380, 16'($urandom()));
        send_request(CMD_FREE, 16'($urandom()), 16'd3);
        send_request(CMD_ALLOC, 16'd61379, 16'($urandom()));
        send_request(CMD_FREE, 16'($urandom()), 16'd3);

        // Random part in phases of different idling; the last phase starts
        // with a long receiver hold-off while requests keep coming.
        for (phase = 0; phase < PHASES; phase++) begin
            unique case (phase)
                1: begin
                    sender_idle_pct    = 58;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 58;
                end
                3: begin
                    sender_idle_pct    = 6;
                    receiver_stall_pct = 6;
                end
                4: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    hold_off_start     = 1'b1;
                end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                pick_random_request(rnd_cmd, rnd_size, rnd_addr);
                send_request(rnd_cmd, rnd_size, rnd_addr);
            end
        end
        s_valid <= 1'b0;

        // Wait for every outstanding result, then give the block time to show
        // any stray result before the verdict.
        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (error_count == 0) begin
            $display("[first_fit_heap_allocator] OK");
        end else begin
            $display("[first_fit_heap_allocator] ERROR");
        end
        $finish;
    end

endmodule
